FILE: design/modular_poly_evaluator_macros.svh
// Assertion macros used by the evaluator's top level.
`ifndef MODULAR_POLY_EVALUATOR_MACROS_SVH
`define MODULAR_POLY_EVALUATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mpe_pkg.sv
// Shared types and constants of the modular polynomial evaluator.
package mpe_pkg;

  localparam int unsigned MAX_TERMS_DEF = 256;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned COEF_IDX_W    = 8;
  localparam int unsigned DEGREE_W      = 8;
  localparam int unsigned MODULUS_RST   = 7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Register index, taken from the top address bit
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_DEGREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_RUN,
    ST_FIN,
    ST_RED,
    ST_WR
  } state_e;

  typedef struct packed {
    logic init;   // clear accumulator, latch point
    logic start;  // latch coefficient, begin one term
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;   // last step of the term this cycle
  } mac_stat_t;

endpackage

FILE: design/mpe_coef_mem.sv
// Coefficient store: one write port, one registered read port.
module mpe_coef_mem import mpe_pkg::*; #(
  parameter int unsigned DEPTH = MAX_TERMS_DEF,
  parameter int unsigned WIDTH = WORD_BITS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/mpe_mac.sv
// Bit-serial modular multiply-add: acc <- (acc * x + c) mod m, one bit per cycle.
module mpe_mac import mpe_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_ctrl_t            ctrl_i,
  input  logic [WORD_BITS-1:0] mod_i,
  input  logic [WORD_BITS-1:0] point_i,
  input  logic [WORD_BITS-1:0] coef_i,
  output mac_stat_t            stat_o,
  output logic [WORD_BITS-1:0] acc_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  acc_q, r_q, c_q, x_q;
  logic [W:0]    m_ext, t1, t2;
  logic [W-1:0]  t1r, step;

  // Horner over bits, msb first: r = 2r + c_bit + x_bit*acc, kept below m
  always_comb begin
    m_ext = {1'b0, mod_i};
    t1    = {r_q, 1'b0} + {{W{1'b0}}, c_q[W-1]};
    t1r   = (t1 >= m_ext) ? W'(t1 - m_ext) : t1[W-1:0];
    t2    = {1'b0, t1r} + (x_q[W-1] ? {1'b0, acc_q} : {(W+1){1'b0}});
    step  = (t2 >= m_ext) ? W'(t2 - m_ext) : t2[W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      acc_q <= '0;
      x_q   <= point_i;
    end
    if (ctrl_i.start) begin
      c_q <= coef_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= step;
      c_q <= {c_q[W-2:0], 1'b0};
      x_q <= {x_q[W-2:0], x_q[W-1]};   // rotates back after one term
      if (cnt_q == LAST) begin
        acc_q <= step;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == LAST);
  assign acc_o       = acc_q;

endmodule

FILE: design/modular_poly_evaluator.sv
// Top level of the modular polynomial evaluator.
//
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tuser: op; tdata: coef_index, coef_value, point
//  m_axis    out  tvalid/tready        tdata: value
//  apb       in   psel/penable/pwrite  paddr, pwdata (modulus, degree); prdata
//
// A load word runs its coefficient through the multiply-add with a zero
// accumulator to reduce it, then writes the store. An evaluate word runs each
// term as one store read plus WORD_BITS multiply-add steps, and skips the terms
// when the modulus is below two.
// Input is taken only in idle; the result register lets a new word in while
// the last result waits, and a finished evaluation holds until it is free.
// Reset clears control and loads the configuration defaults; the store needs no clearing pass.
`include "modular_poly_evaluator_macros.svh"

module modular_poly_evaluator import mpe_pkg::*; #(
  parameter int unsigned MAX_TERMS = MAX_TERMS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  localparam int unsigned IN_W   = ((COEF_IDX_W + 2 * WORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W  = ((WORD_BITS + 7) / 8) * 8,
  localparam int unsigned APB_DW = (WORD_BITS > 32) ? 64 : 32,
  localparam int unsigned PAW    = (WORD_BITS > 32) ? 4 : 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [IN_W-1:0]   s_axis_tdata_i,   // coef_index, coef_value, point
  input  logic              s_axis_tuser_i,   // op
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_W-1:0]  m_axis_tdata_o,   // value
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAW-1:0]    paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned IW = $clog2(MAX_TERMS);

  // Input word fields
  logic [COEF_IDX_W-1:0] in_idx;
  logic [W-1:0]          in_coef, in_point;
  assign in_idx   = s_axis_tdata_i[COEF_IDX_W-1:0];
  assign in_coef  = s_axis_tdata_i[COEF_IDX_W +: W];
  assign in_point = s_axis_tdata_i[COEF_IDX_W + W +: W];

  // Configuration registers
  logic [W-1:0]        mod_q;
  logic [DEGREE_W-1:0] deg_q;
  logic                cfg_we;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[PAW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= W'(MODULUS_RST);
      deg_q <= '0;
    end else if (cfg_we) begin
      if (reg_sel == REG_MODULUS) begin
        mod_q <= pwdata[W-1:0];
      end else begin
        deg_q <= pwdata[DEGREE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_MODULUS: prdata = APB_DW'(mod_q);
      REG_DEGREE:  prdata = APB_DW'(deg_q);
      default:     prdata = '0;
    endcase
  end

  // Highest term index, clamped to the store
  logic [31:0]   top_full;
  logic [IW-1:0] top_idx;
  always_comb begin
    top_full = (32'(deg_q) > 32'(MAX_TERMS - 1)) ? 32'(MAX_TERMS - 1) : 32'(deg_q);
    top_idx  = top_full[IW-1:0];
  end

  // Control
  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          out_vld_q, out_vld_d;
  logic [W-1:0]  out_q;
  logic          in_acc, out_load, mod_small;
  logic          ld_go, ev_go;
  mac_ctrl_t     mac_ctrl;
  mac_stat_t     mac_st;
  logic [W-1:0]  acc, rdata;
  logic [W-1:0]  mac_coef, mem_wdata;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign mod_small = (mod_q < W'(2));

  // Loads beyond the store are dropped
  assign ld_go = in_acc && (s_axis_tuser_i == OP_LOAD) &&
                 (32'(in_idx) < 32'(MAX_TERMS));
  assign ev_go = in_acc && (s_axis_tuser_i == OP_EVAL);

  // Load path: reduced coefficient (zero for a tiny modulus) lands at idx_q
  assign mem_we    = (state_q == ST_WR);
  assign mem_waddr = idx_q;
  assign mem_wdata = mod_small ? '0 : acc;
  assign mac_coef  = (state_q == ST_IDLE) ? in_coef : rdata;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (ev_go) begin
          idx_d   = top_idx;
          state_d = mod_small ? ST_FIN : ST_RD;
        end else if (ld_go) begin
          idx_d   = IW'(in_idx);
          state_d = ST_RED;
        end
      end
      ST_RD:   state_d = ST_LD;
      ST_LD:   state_d = ST_RUN;
      ST_RUN: begin
        if (mac_st.done) begin
          if (idx_q == '0) begin
            state_d = ST_FIN;
          end else begin
            idx_d   = idx_q - IW'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (!out_vld_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_RED: begin
        if (mac_st.done) begin
          state_d = ST_WR;
        end
      end
      ST_WR:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    mac_ctrl.init   = ld_go || ev_go;
    mac_ctrl.start  = (state_q == ST_LD) || ld_go;
    out_load        = (state_q == ST_FIN) && (!out_vld_q || m_axis_tready_i);
    out_vld_d       = out_vld_q;
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Accumulator is zero when the modulus is below two
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= acc;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'(out_q);

  mpe_coef_mem #(
    .DEPTH (MAX_TERMS),
    .WIDTH (W),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  mpe_mac #(
    .WORD_BITS (W)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .mod_i   (mod_q),
    .point_i (in_point),
    .coef_i  (mac_coef),
    .stat_o  (mac_st),
    .acc_o   (acc)
  );

  `MPE_ASSERT_NOW(a_mac_idle, state_q == ST_IDLE, !mac_st.busy, "mac busy while idle")
  `MPE_ASSERT_NEXT(a_idx_step, state_q == ST_RUN && mac_st.done && idx_q != '0, state_q == ST_RD && idx_q == $past(idx_q) - IW'(1), "term index did not step down")
  `MPE_ASSERT_NEXT(a_out_src, !out_vld_q && state_q != ST_FIN, !out_vld_q, "result appeared without finishing")

endmodule
